[rtl/idq_pkg.sv]
// ----------------------------------------------------------------------------
// idq_pkg
// shared types and constants for the indexed deque with cursor
// ----------------------------------------------------------------------------
package idq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  localparam logic [3:0] ModePushFront = 4'd0;
  localparam logic [3:0] ModePushBack  = 4'd1;
  localparam logic [3:0] ModeInsert    = 4'd2;
  localparam logic [3:0] ModePopFront  = 4'd3;
  localparam logic [3:0] ModePopBack   = 4'd4;
  localparam logic [3:0] ModeRemoveAt  = 4'd5;
  localparam logic [3:0] ModeNext      = 4'd6;
  localparam logic [3:0] ModePrev      = 4'd7;
  localparam logic [3:0] ModeCurrent   = 4'd8;
  localparam logic [3:0] ModeClear     = 4'd9;
  localparam logic [3:0] ModeDump      = 4'd10;
  localparam logic [3:0] ModeDumpRev   = 4'd11;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StEmpty = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef enum logic [2:0] {
    OpNone, OpInsert, OpRemove, OpSetCursor, OpClear
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e          op;
    logic [IdxW-1:0] at;
    logic [IdxW-1:0] cur;
    logic [31:0]     word;
    logic [IdxW-1:0] rd_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic [IdxW-1:0] cursor;
    logic [31:0]     rd_word;
  } dp_stat_t;

endpackage

[rtl/idq_datapath.sv]
// ----------------------------------------------------------------------------
// idq_datapath
// shifting cell chain with count and cursor registers
// ----------------------------------------------------------------------------
module idq_datapath import idq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o
);

  logic [31:0]     cell_q [Capacity];
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] cursor_q;

  // each cell chooses among hold, left neighbor, right neighbor or new word
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Capacity; i++) begin
      if (cmd_i.op == OpInsert) begin
        if (IdxW'(i) == cmd_i.at) begin
          cell_q[i] <= cmd_i.word;
        end else if (IdxW'(i) > cmd_i.at && i > 0) begin
          cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.op == OpRemove) begin
        if (IdxW'(i) >= cmd_i.at && i < Capacity - 1) begin
          cell_q[i] <= cell_q[(i < Capacity - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      case (cmd_i.op)
        OpInsert: begin
          count_q  <= count_q + CntW'(1);
          cursor_q <= cmd_i.at;
        end
        OpRemove: begin
          count_q  <= count_q - CntW'(1);
          cursor_q <= cmd_i.cur;
        end
        OpSetCursor: cursor_q <= cmd_i.cur;
        OpClear: begin
          count_q  <= '0;
          cursor_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.count   = count_q;
  assign stat_o.cursor  = cursor_q;
  assign stat_o.rd_word = cell_q[cmd_i.rd_idx];

endmodule

[rtl/idq_ctrl.sv]
// ----------------------------------------------------------------------------
// idq_ctrl
// decodes an operation, drives the datapath and sequences result beats
// ----------------------------------------------------------------------------
module idq_ctrl import idq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [31:0] data_word_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_word_o,
  output logic [1:0]  status_o,
  output logic [4:0]  occupancy_o,
  output logic [3:0]  cursor_pos_o,
  output logic        last_of_run_o,
  output dp_cmd_t     cmd_o,
  input  dp_stat_t    stat_i
);

  typedef enum logic [1:0] {SIdle, SDump, SOut} state_e;

  state_e          state_q;
  logic [IdxW-1:0] dmp_q;      // entries emitted so far
  logic            dmp_rev_q;
  logic [IdxW-1:0] dmp_last;
  logic [31:0]     word_q;
  logic [1:0]      st_q;
  logic            last_q;
  logic            acc;
  logic            full, empty;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] lasti, posi;
  logic            pos_big, pos_rm_end;

  assign cnt   = stat_i.count;
  assign full  = cnt >= CntW'(Capacity);
  assign empty = cnt == '0;
  assign lasti = IdxW'(cnt - CntW'(1));
  assign posi  = IdxW'(position_i);
  assign pos_big    = {1'b0, position_i} >= 9'(cnt);
  assign pos_rm_end = {1'b0, position_i} + 9'd1 >= 9'(cnt);
  assign dmp_last   = IdxW'(cnt - CntW'(1));
  assign in_ready_o = state_q == SIdle;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OpNone;
    cmd_o.word = data_word_i;
    if (state_q == SDump) begin
      cmd_o.rd_idx = dmp_rev_q ? IdxW'(dmp_last - dmp_q) : dmp_q;
    end else begin
      cmd_o.rd_idx = stat_i.cursor;
    end
    if (acc) begin
      case (mode_i)
        ModePushFront, ModePushBack, ModeInsert: begin
          if (!full) begin
            cmd_o.op = OpInsert;
            if (mode_i == ModePushFront || empty || (mode_i == ModeInsert && posi == '0 &&
                position_i == 8'd0)) begin
              cmd_o.at = '0;
            end else if (mode_i == ModePushBack || pos_big) begin
              cmd_o.at = IdxW'(cnt);
            end else begin
              cmd_o.at = posi;
            end
          end
        end
        ModePopFront, ModePopBack, ModeRemoveAt: begin
          if (!empty) begin
            cmd_o.op = OpRemove;
            if (mode_i == ModePopFront || (mode_i == ModeRemoveAt && position_i == 8'd0)) begin
              cmd_o.at  = '0;
              cmd_o.cur = '0;
            end else if (mode_i == ModePopBack || pos_rm_end) begin
              cmd_o.at  = lasti;
              cmd_o.cur = (cnt > CntW'(1)) ? IdxW'(cnt - CntW'(2)) : '0;
            end else begin
              cmd_o.at  = posi;
              cmd_o.cur = posi;
            end
            cmd_o.rd_idx = cmd_o.at;
          end
        end
        ModeNext: begin
          if (!empty) begin
            cmd_o.op  = OpSetCursor;
            cmd_o.cur = (CntW'(stat_i.cursor) + CntW'(1) < cnt) ?
                        stat_i.cursor + IdxW'(1) : stat_i.cursor;
            cmd_o.rd_idx = cmd_o.cur;
          end
        end
        ModePrev: begin
          if (!empty) begin
            cmd_o.op  = OpSetCursor;
            cmd_o.cur = (stat_i.cursor != '0) ? stat_i.cursor - IdxW'(1) : '0;
            cmd_o.rd_idx = cmd_o.cur;
          end
        end
        ModeClear: cmd_o.op = OpClear;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      dmp_q     <= '0;
      dmp_rev_q <= 1'b0;
      word_q    <= '0;
      st_q      <= StOk;
      last_q    <= 1'b0;
    end else begin
      case (state_q)
        SIdle: begin
          if (acc) begin
            word_q <= '0;
            st_q   <= StOk;
            last_q <= 1'b1;
            state_q <= SOut;
            case (mode_i)
              ModePushFront, ModePushBack, ModeInsert: if (full) st_q <= StFull;
              ModePopFront, ModePopBack, ModeRemoveAt, ModeNext, ModePrev, ModeCurrent:
                if (empty) st_q <= StEmpty;
                else word_q <= stat_i.rd_word;
              ModeDump, ModeDumpRev: begin
                if (empty) st_q <= StEmpty;
                else begin
                  state_q   <= SDump;
                  dmp_q     <= '0;
                  dmp_rev_q <= mode_i == ModeDumpRev;
                end
              end
              default: ;
            endcase
          end
        end
        SDump: begin
          word_q  <= stat_i.rd_word;
          st_q    <= StOk;
          last_q  <= dmp_q == dmp_last;
          state_q <= SOut;
        end
        SOut: begin
          if (out_ready_i) begin
            if (last_q) begin
              state_q <= SIdle;
            end else begin
              dmp_q   <= dmp_q + IdxW'(1);
              state_q <= SDump;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o   = state_q == SOut;
  assign read_word_o   = word_q;
  assign status_o      = st_q;
  assign occupancy_o   = 5'(cnt);
  assign cursor_pos_o  = 4'(stat_i.cursor);
  assign last_of_run_o = last_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> cmd_o.op == OpNone)
    else $error("datapath command while busy");
  a_full_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OpInsert) |-> !full)
    else $error("insert on full list");
  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt == '0) |-> stat_i.cursor == '0)
    else $error("cursor off zero on empty list");

endmodule

[rtl/indexed_deque_with_cursor.sv]
// ----------------------------------------------------------------------------
// indexed_deque_with_cursor
// bounded deque of 32-bit words in a shifting cell chain, with a cursor
// ----------------------------------------------------------------------------
// the result beat is registered and appears in the cycle after accept; a dump's first
// beat passes through the SDump read state before SOut, and each later beat passes
// through SDump again once the sink has taken the beat before it;
// the input is held off until the last beat of an item is taken
// reset: count and cursor clear to zero; cell contents are not reset
module indexed_deque_with_cursor import idq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  mode_i,
  input  logic [31:0] data_word_i,
  input  logic [7:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_word_o,
  output logic [1:0]  status_o,
  output logic [4:0]  occupancy_o,
  output logic [3:0]  cursor_pos_o,
  output logic        last_of_run_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  idq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .data_word_i,
    .position_i, .out_valid_o, .out_ready_i, .read_word_o, .status_o,
    .occupancy_o, .cursor_pos_o, .last_of_run_o,
    .cmd_o(cmd), .stat_i(stat)
  );

  idq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat)
  );

endmodule
